// ===== design/modular_square_root_lift_core_macros.svh =====
// assertion helpers for the modular square root core
`ifndef MODULAR_SQUARE_ROOT_LIFT_CORE_MACROS_SVH
`define MODULAR_SQUARE_ROOT_LIFT_CORE_MACROS_SVH

// antecedent implies consequent in the same cycle
`define MSLC_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("mslc implication check failed");

// condition never holds
`define MSLC_ASSERT_NEVER(lbl, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error("mslc forbidden condition seen");

`endif

// ===== design/mslc_pkg.sv =====
package mslc_pkg;

    localparam int DATA_W       = 64;
    localparam int MOD_W        = 32;
    localparam int NONRES_LIMIT = 4096;
    localparam int W_W          = 13;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_NONRES = 2'd1;
    localparam logic [1:0] ST_NOLIFT = 2'd2;
    localparam logic [1:0] ST_BADMOD = 2'd3;

    localparam logic [1:0] LIFT_RESET = 2'd2;

    typedef enum logic [5:0] {
        S_IDLE, S_CHECK, S_NR, S_EUL, S_P3, S_QS, S_WTEST, S_WCHK,
        S_GOTC, S_GOTT, S_GOTR, S_ROUND, S_ORD, S_ORD_B, S_BSQ, S_BSQ_B,
        S_R2, S_T1, S_T1B, S_T2, S_VERIFY, S_VCHK, S_L0, S_L1,
        S_L2, S_L3, S_L4, S_EU, S_EU_Q, S_EU_T, S_H, S_H2,
        S_H3, S_POW, S_POW_A, S_POW_SQ, S_POW_B, S_MUL, S_DSTART, S_DWAIT,
        S_OUT
    } t_state;

    typedef struct packed {
        logic start;
    } t_div_ctl;

    typedef struct packed {
        logic done;
    } t_div_sts;

endpackage

// ===== design/mslc_in_if.sv =====
interface mslc_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] residue_value;
    logic [31:0] prime_modulus;

    modport source (output valid, output residue_value, output prime_modulus, input ready);
    modport sink   (input valid, input residue_value, input prime_modulus, output ready);
endinterface

// ===== design/mslc_out_if.sv =====
interface mslc_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] root;
    logic [1:0]  status;

    modport source (output valid, output root, output status, input ready);
    modport sink   (input valid, input root, input status, output ready);
endinterface

// ===== design/mslc_cfg_if.sv =====
interface mslc_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] lift_exponent;

    modport source (output valid, output lift_exponent, input ready);
    modport sink   (input valid, input lift_exponent, output ready);
endinterface

// ===== design/mslc_div.sv =====
module mslc_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  mslc_pkg::t_div_ctl             i_ctl,
    input  logic [mslc_pkg::DATA_W-1:0]    i_dividend,
    input  logic [mslc_pkg::DATA_W-1:0]    i_divisor,
    output mslc_pkg::t_div_sts             o_sts,
    output logic [mslc_pkg::DATA_W-1:0]    o_quotient,
    output logic [mslc_pkg::DATA_W-1:0]    o_remainder
);

    localparam int CNT_W = $clog2(mslc_pkg::DATA_W);

    logic                          r_busy;
    logic [CNT_W-1:0]              r_cnt;
    logic [mslc_pkg::DATA_W-1:0]   r_rem;
    logic [mslc_pkg::DATA_W-1:0]   r_quo;
    logic [mslc_pkg::DATA_W:0]     sh;
    logic [mslc_pkg::DATA_W:0]     dvs_ext;
    logic [mslc_pkg::DATA_W:0]     diff;
    logic                          fits;

    assign sh      = {r_rem, r_quo[mslc_pkg::DATA_W-1]};
    assign dvs_ext = {1'b0, i_divisor};
    assign fits    = sh >= dvs_ext;
    assign diff    = sh - dvs_ext;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_ctl.start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == CNT_W'(mslc_pkg::DATA_W - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_rem <= fits ? diff[mslc_pkg::DATA_W-1:0] : sh[mslc_pkg::DATA_W-1:0];
            r_quo <= {r_quo[mslc_pkg::DATA_W-2:0], fits};
        end
    end

    assign o_sts.done  = r_busy && (r_cnt == CNT_W'(mslc_pkg::DATA_W - 1));
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

// ===== design/modular_square_root_lift_core.sv =====
// modular square root with optional lift to the prime squared
// i_item carries residue_value and prime_modulus; o_result returns root and status
// i_cfg writes lift_exponent: 1 or 0 gives a root mod p, 2 or 3 a root mod p squared
// one item is worked at a time: i_item.ready is high only while the core is idle
// all multiplies and divisions run through one restoring divider and one 32x32 multiplier
// a modular multiply is one product and one division, a modular power up to about 64 of them
// a bad modulus goes straight to o_result, a residue divisible by p after one division;
//   p = 3 mod 4 takes two exponentiations, other primes more, growing with the
//   non-residue search and the 2-adic order
// the lift adds an extended euclid pass, each step one division and one multiply
// a result stays on o_result until taken; the core accepts nothing while it waits
// reset returns to idle, drops any item in flight and sets lift_exponent to 2
// i_cfg.ready is always high; write it only while the core is idle
`include "modular_square_root_lift_core_macros.svh"

module modular_square_root_lift_core (
    input  logic         i_clk,
    input  logic         i_rst_n,
    mslc_in_if.sink      i_item,
    mslc_cfg_if.sink     i_cfg,
    mslc_out_if.source   o_result
);

    mslc_pkg::t_state r_state, n_state, r_dret, r_pret;

    logic [1:0]  r_lift_exp;
    logic        r_lift;
    logic [63:0] r_n;
    logic [31:0] r_p, r_nr, r_q, r_c, r_t, r_r, r_y, r_bb;
    logic [31:0] r_pb, r_pe, r_pacc, r_ma, r_mb;
    logic [31:0] r_kq, r_r0, r_r1, r_t0, r_t1;
    logic [4:0]  r_s;
    logic [5:0]  r_round, r_i, r_k;
    logic [mslc_pkg::W_W-1:0] r_w;
    logic [63:0] r_dvd, r_dvs, r_pp, r_n2, r_b2;
    logic [63:0] r_root;
    logic [1:0]  r_st;

    mslc_pkg::t_div_ctl div_ctl;
    mslc_pkg::t_div_sts div_sts;
    logic [63:0] div_quo, div_rem;
    logic [31:0] rem32;
    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_p;
    logic        bad_mod, w_ok, ord_loop, ord_fail, bsq_loop;
    logic [32:0] p_plus1, two_b, two_b_red, eu_nt;
    logic [63:0] diff;

    mslc_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (div_ctl),
        .i_dividend  (r_dvd),
        .i_divisor   (r_dvs),
        .o_sts       (div_sts),
        .o_quotient  (div_quo),
        .o_remainder (div_rem)
    );

    assign rem32   = div_rem[31:0];
    assign div_ctl.start = (r_state == mslc_pkg::S_DSTART);

    always_comb begin
        unique case (r_state)
            mslc_pkg::S_L0: begin mul_a = r_p;   mul_b = r_p; end
            mslc_pkg::S_L2: begin mul_a = r_r;   mul_b = r_r; end
            mslc_pkg::S_H2: begin mul_a = rem32; mul_b = r_p; end
            default:        begin mul_a = r_ma;  mul_b = r_mb; end
        endcase
    end
    assign mul_p = {32'b0, mul_a} * {32'b0, mul_b};

    assign bad_mod   = (r_p < 32'd3) || !r_p[0];
    assign w_ok      = ({19'b0, r_w} < r_p) && (r_w <= mslc_pkg::W_W'(mslc_pkg::NONRES_LIMIT));
    assign ord_loop  = (r_y != 32'd1) && (r_i < {1'b0, r_s});
    assign ord_fail  = (r_y != 32'd1) || (r_i >= {1'b0, r_s});
    assign bsq_loop  = ({1'b0, r_k} + {1'b0, r_i} + 7'd1) < {2'b0, r_s};
    assign p_plus1   = {1'b0, r_p} + 33'd1;
    assign two_b     = {r_r, 1'b0};
    assign two_b_red = (two_b >= {1'b0, r_p}) ? two_b - {1'b0, r_p} : two_b;
    assign eu_nt     = (r_t0 >= rem32) ? {1'b0, r_t0 - rem32}
                                       : {1'b0, r_t0} + {1'b0, r_p} - {1'b0, rem32};
    assign diff      = (r_n2 >= r_b2) ? r_n2 - r_b2 : r_n2 + (r_pp - r_b2);

    assign i_item.ready   = (r_state == mslc_pkg::S_IDLE);
    assign i_cfg.ready    = 1'b1;
    assign o_result.valid = (r_state == mslc_pkg::S_OUT);
    assign o_result.root  = r_root;
    assign o_result.status = r_st;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= mslc_pkg::S_IDLE;
            r_lift_exp <= mslc_pkg::LIFT_RESET;
        end else begin
            r_state <= n_state;
            if (i_cfg.valid) begin
                r_lift_exp <= i_cfg.lift_exponent;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            mslc_pkg::S_IDLE:   if (i_item.valid) n_state = mslc_pkg::S_CHECK;
            mslc_pkg::S_CHECK:  n_state = bad_mod ? mslc_pkg::S_OUT : mslc_pkg::S_DSTART;
            mslc_pkg::S_NR:     n_state = (rem32 == 32'd0) ? mslc_pkg::S_OUT : mslc_pkg::S_POW;
            mslc_pkg::S_EUL: begin
                if (r_pacc != 32'd1)   n_state = mslc_pkg::S_OUT;
                else if (r_p[1])       n_state = mslc_pkg::S_POW;
                else                   n_state = mslc_pkg::S_QS;
            end
            mslc_pkg::S_P3:     n_state = mslc_pkg::S_VERIFY;
            mslc_pkg::S_QS:     n_state = r_q[0] ? mslc_pkg::S_WTEST : mslc_pkg::S_QS;
            mslc_pkg::S_WTEST:  n_state = w_ok ? mslc_pkg::S_POW : mslc_pkg::S_OUT;
            mslc_pkg::S_WCHK:   n_state = (r_pacc == r_p - 32'd1) ? mslc_pkg::S_POW
                                                                  : mslc_pkg::S_WTEST;
            mslc_pkg::S_GOTC:   n_state = mslc_pkg::S_POW;
            mslc_pkg::S_GOTT:   n_state = mslc_pkg::S_POW;
            mslc_pkg::S_GOTR:   n_state = mslc_pkg::S_ROUND;
            mslc_pkg::S_ROUND: begin
                priority if (r_round > {1'b0, r_s}) n_state = mslc_pkg::S_OUT;
                else if (r_t == 32'd1)             n_state = mslc_pkg::S_VERIFY;
                else                               n_state = mslc_pkg::S_ORD;
            end
            mslc_pkg::S_ORD: begin
                priority if (ord_loop) n_state = mslc_pkg::S_MUL;
                else if (ord_fail)     n_state = mslc_pkg::S_OUT;
                else                   n_state = mslc_pkg::S_BSQ;
            end
            mslc_pkg::S_ORD_B:  n_state = mslc_pkg::S_ORD;
            mslc_pkg::S_BSQ:    n_state = mslc_pkg::S_MUL;
            mslc_pkg::S_BSQ_B:  n_state = mslc_pkg::S_BSQ;
            mslc_pkg::S_R2:     n_state = mslc_pkg::S_MUL;
            mslc_pkg::S_T1:     n_state = mslc_pkg::S_T1B;
            mslc_pkg::S_T1B:    n_state = mslc_pkg::S_MUL;
            mslc_pkg::S_T2:     n_state = mslc_pkg::S_ROUND;
            mslc_pkg::S_VERIFY: n_state = mslc_pkg::S_MUL;
            mslc_pkg::S_VCHK:   n_state = (rem32 != r_nr || !r_lift) ? mslc_pkg::S_OUT
                                                                    : mslc_pkg::S_L0;
            mslc_pkg::S_L0:     n_state = mslc_pkg::S_DSTART;
            mslc_pkg::S_L1:     n_state = mslc_pkg::S_L2;
            mslc_pkg::S_L2:     n_state = mslc_pkg::S_L3;
            mslc_pkg::S_L3:     n_state = mslc_pkg::S_DSTART;
            mslc_pkg::S_L4:     n_state = mslc_pkg::S_EU;
            mslc_pkg::S_EU: begin
                priority if (r_r1 != 32'd0) n_state = mslc_pkg::S_DSTART;
                else if (r_r0 != 32'd1)    n_state = mslc_pkg::S_OUT;
                else                       n_state = mslc_pkg::S_H;
            end
            mslc_pkg::S_EU_Q:   n_state = mslc_pkg::S_MUL;
            mslc_pkg::S_EU_T:   n_state = mslc_pkg::S_EU;
            mslc_pkg::S_H:      n_state = mslc_pkg::S_MUL;
            mslc_pkg::S_H2:     n_state = mslc_pkg::S_H3;
            mslc_pkg::S_H3:     n_state = mslc_pkg::S_OUT;
            mslc_pkg::S_POW: begin
                priority if (r_pe == 32'd0) n_state = r_pret;
                else if (r_pe[0])          n_state = mslc_pkg::S_MUL;
                else                       n_state = mslc_pkg::S_POW_SQ;
            end
            mslc_pkg::S_POW_A:  n_state = mslc_pkg::S_POW_SQ;
            mslc_pkg::S_POW_SQ: n_state = mslc_pkg::S_MUL;
            mslc_pkg::S_POW_B:  n_state = mslc_pkg::S_POW;
            mslc_pkg::S_MUL:    n_state = mslc_pkg::S_DSTART;
            mslc_pkg::S_DSTART: n_state = mslc_pkg::S_DWAIT;
            mslc_pkg::S_DWAIT:  if (div_sts.done) n_state = r_dret;
            mslc_pkg::S_OUT:    if (o_result.ready) n_state = mslc_pkg::S_IDLE;
            default:            n_state = mslc_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            mslc_pkg::S_IDLE: begin
                r_n    <= i_item.residue_value;
                r_p    <= i_item.prime_modulus;
                r_lift <= r_lift_exp[1];
                r_st   <= mslc_pkg::ST_OK;
                r_root <= '0;
            end
            mslc_pkg::S_CHECK: begin
                if (bad_mod) begin
                    r_st <= mslc_pkg::ST_BADMOD;
                end
                r_dvd  <= r_n;
                r_dvs  <= {32'b0, r_p};
                r_dret <= mslc_pkg::S_NR;
            end
            mslc_pkg::S_NR: begin
                r_nr <= rem32;
                if (rem32 == 32'd0) begin
                    r_st <= r_lift ? mslc_pkg::ST_NOLIFT : mslc_pkg::ST_OK;
                end
                r_pb   <= rem32;
                r_pe   <= {1'b0, r_p[31:1]};
                r_pacc <= 32'd1;
                r_pret <= mslc_pkg::S_EUL;
            end
            mslc_pkg::S_EUL: begin
                r_q <= r_p - 32'd1;
                r_s <= '0;
                if (r_pacc != 32'd1) begin
                    r_st <= mslc_pkg::ST_NONRES;
                end
                r_pb   <= r_nr;
                r_pe   <= {1'b0, p_plus1[32:2]};
                r_pacc <= 32'd1;
                r_pret <= mslc_pkg::S_P3;
            end
            mslc_pkg::S_P3: r_r <= r_pacc;
            mslc_pkg::S_QS: begin
                if (!r_q[0]) begin
                    r_q <= {1'b0, r_q[31:1]};
                    r_s <= r_s + 5'd1;
                end
                r_w <= mslc_pkg::W_W'(2);
            end
            mslc_pkg::S_WTEST: begin
                if (!w_ok) begin
                    r_st <= mslc_pkg::ST_BADMOD;
                end
                r_pb   <= {19'b0, r_w};
                r_pe   <= {1'b0, r_p[31:1]};
                r_pacc <= 32'd1;
                r_pret <= mslc_pkg::S_WCHK;
            end
            mslc_pkg::S_WCHK: begin
                r_w    <= r_w + 1'b1;
                r_pb   <= {19'b0, r_w};
                r_pe   <= r_q;
                r_pacc <= 32'd1;
                r_pret <= mslc_pkg::S_GOTC;
            end
            mslc_pkg::S_GOTC: begin
                r_c    <= r_pacc;
                r_pb   <= r_nr;
                r_pe   <= r_q;
                r_pacc <= 32'd1;
                r_pret <= mslc_pkg::S_GOTT;
            end
            mslc_pkg::S_GOTT: begin
                r_t    <= r_pacc;
                r_pb   <= r_nr;
                r_pe   <= {1'b0, r_q[31:1]} + 32'd1;
                r_pacc <= 32'd1;
                r_pret <= mslc_pkg::S_GOTR;
            end
            mslc_pkg::S_GOTR: begin
                r_r     <= r_pacc;
                r_round <= '0;
            end
            mslc_pkg::S_ROUND: begin
                if (r_round > {1'b0, r_s}) begin
                    r_st <= mslc_pkg::ST_BADMOD;
                end
                r_y <= r_t;
                r_i <= '0;
            end
            mslc_pkg::S_ORD: begin
                if (ord_loop) begin
                    r_ma   <= r_y;
                    r_mb   <= r_y;
                    r_dret <= mslc_pkg::S_ORD_B;
                end else if (ord_fail) begin
                    r_st <= mslc_pkg::ST_BADMOD;
                end
                r_bb <= r_c;
                r_k  <= '0;
            end
            mslc_pkg::S_ORD_B: begin
                r_y <= rem32;
                r_i <= r_i + 6'd1;
            end
            mslc_pkg::S_BSQ: begin
                if (bsq_loop) begin
                    r_ma   <= r_bb;
                    r_mb   <= r_bb;
                    r_dret <= mslc_pkg::S_BSQ_B;
                end else begin
                    r_ma   <= r_r;
                    r_mb   <= r_bb;
                    r_dret <= mslc_pkg::S_R2;
                end
            end
            mslc_pkg::S_BSQ_B: begin
                r_bb <= rem32;
                r_k  <= r_k + 6'd1;
            end
            mslc_pkg::S_R2: begin
                r_r    <= rem32;
                r_ma   <= r_bb;
                r_mb   <= r_bb;
                r_dret <= mslc_pkg::S_T1;
            end
            mslc_pkg::S_T1:  r_bb <= rem32;
            mslc_pkg::S_T1B: begin
                r_ma   <= r_t;
                r_mb   <= r_bb;
                r_dret <= mslc_pkg::S_T2;
            end
            mslc_pkg::S_T2: begin
                r_t     <= rem32;
                r_round <= r_round + 6'd1;
            end
            mslc_pkg::S_VERIFY: begin
                r_ma   <= r_r;
                r_mb   <= r_r;
                r_dret <= mslc_pkg::S_VCHK;
            end
            mslc_pkg::S_VCHK: begin
                if (rem32 != r_nr) begin
                    r_st <= mslc_pkg::ST_BADMOD;
                end else if (!r_lift) begin
                    r_root <= {32'b0, r_r};
                end
            end
            mslc_pkg::S_L0: begin
                r_pp   <= mul_p;
                r_dvs  <= mul_p;
                r_dvd  <= r_n;
                r_dret <= mslc_pkg::S_L1;
            end
            mslc_pkg::S_L1: r_n2 <= div_rem;
            mslc_pkg::S_L2: r_b2 <= mul_p;
            mslc_pkg::S_L3: begin
                r_dvd  <= diff;
                r_dvs  <= {32'b0, r_p};
                r_dret <= mslc_pkg::S_L4;
            end
            mslc_pkg::S_L4: begin
                r_kq <= div_quo[31:0];
                r_r0 <= r_p;
                r_r1 <= two_b_red[31:0];
                r_t0 <= '0;
                r_t1 <= 32'd1;
            end
            mslc_pkg::S_EU: begin
                if (r_r1 == 32'd0 && r_r0 != 32'd1) begin
                    r_st <= mslc_pkg::ST_BADMOD;
                end
                r_dvd  <= {32'b0, r_r0};
                r_dvs  <= {32'b0, r_r1};
                r_dret <= mslc_pkg::S_EU_Q;
            end
            mslc_pkg::S_EU_Q: begin
                r_ma   <= (div_quo == {32'b0, r_p}) ? 32'd0 : div_quo[31:0];
                r_mb   <= r_t1;
                r_r0   <= r_r1;
                r_r1   <= rem32;
                r_dret <= mslc_pkg::S_EU_T;
            end
            mslc_pkg::S_EU_T: begin
                r_t0 <= r_t1;
                r_t1 <= eu_nt[31:0];
            end
            mslc_pkg::S_H: begin
                r_ma   <= r_kq;
                r_mb   <= r_t0;
                r_dret <= mslc_pkg::S_H2;
            end
            mslc_pkg::S_H2: r_dvd <= mul_p;
            mslc_pkg::S_H3: r_root <= {32'b0, r_r} + r_dvd;
            mslc_pkg::S_POW: begin
                if (r_pe[0]) begin
                    r_ma   <= r_pacc;
                    r_mb   <= r_pb;
                    r_dret <= mslc_pkg::S_POW_A;
                end
            end
            mslc_pkg::S_POW_A: r_pacc <= rem32;
            mslc_pkg::S_POW_SQ: begin
                r_ma   <= r_pb;
                r_mb   <= r_pb;
                r_dret <= mslc_pkg::S_POW_B;
            end
            mslc_pkg::S_POW_B: begin
                r_pb <= rem32;
                r_pe <= {1'b0, r_pe[31:1]};
            end
            mslc_pkg::S_MUL: begin
                r_dvd <= mul_p;
                r_dvs <= {32'b0, r_p};
            end
            default: begin
            end
        endcase
    end

    `MSLC_ASSERT_IMPLY(a_zero_on_error, o_result.valid && r_st != mslc_pkg::ST_OK, r_root == '0)
    `MSLC_ASSERT_NEVER(a_one_item_at_a_time, i_item.ready && o_result.valid)
    `MSLC_ASSERT_IMPLY(a_root_below_p, o_result.valid && !r_lift && !bad_mod, r_root < 64'(r_p))
    `MSLC_ASSERT_IMPLY(a_div_done_in_wait, div_sts.done, r_state == mslc_pkg::S_DWAIT)

endmodule

// ===== test/tb_modular_square_root_lift_core.sv =====
`timescale 1ns / 100ps

module tb_modular_square_root_lift_core;

    localparam int LIMIT_CYCLES = 400_000_000;
    localparam int HOLD_CYCLES  = 30_000;

    typedef struct {
        logic [63:0] root;
        logic [1:0]  status;
    } t_root_result;

    class sqrt_scoreboard;
        t_root_result want_q[$];
        logic [1:0]   lift_exp;
        int           errors;
        int           items;
        int           results;

        function new();
            lift_exp = mslc_pkg::LIFT_RESET;
            errors   = 0;
            items    = 0;
            results  = 0;
        endfunction

        function bit [63:0] mulm(bit [63:0] a, bit [63:0] b, bit [63:0] m);
            return (a * b) % m;
        endfunction

        function bit [63:0] powm(bit [63:0] base, bit [63:0] ex, bit [63:0] m);
            bit [63:0] acc;
            acc  = 1 % m;
            base = base % m;
            while (ex != 0) begin
                if (ex[0])
                    acc = mulm(acc, base, m);
                base = mulm(base, base, m);
                ex   = ex >> 1;
            end
            return acc;
        endfunction

        function bit invm(bit [63:0] x, bit [63:0] m, output bit [63:0] inv);
            bit [63:0] r0, r1, t0, t1, qq, nr, nt;
            r0  = m;
            r1  = x % m;
            t0  = 0;
            t1  = 1 % m;
            inv = 0;
            while (r1 != 0) begin
                qq = r0 / r1;
                nr = r0 - qq * r1;
                nt = (t0 + m - mulm(qq % m, t1, m)) % m;
                r0 = r1;
                r1 = nr;
                t0 = t1;
                t1 = nt;
            end
            if (r0 != 1)
                return 0;
            inv = t0;
            return 1;
        endfunction

        // tonelli-shanks root mod p, with shortcut for p = 3 mod 4
        function logic [1:0] root_mod_prime(bit [63:0] nr, bit [63:0] p, output bit [63:0] rt);
            bit [63:0] q, c, t, r, w, y, b;
            int unsigned s, rnd, i, k;
            bit found;
            s  = 0;
            rt = 0;
            found = 0;
            if (powm(nr, (p - 1) >> 1, p) != 1)
                return mslc_pkg::ST_NONRES;
            if (p[1]) begin
                r = powm(nr, (p + 1) >> 2, p);
            end else begin
                q = p - 1;
                while (q[0] == 0) begin
                    q = q >> 1;
                    s++;
                end
                for (w = 2; w < p && w <= mslc_pkg::NONRES_LIMIT; w++) begin
                    if (powm(w, (p - 1) >> 1, p) == p - 1) begin
                        found = 1;
                        break;
                    end
                end
                if (!found)
                    return mslc_pkg::ST_BADMOD;
                c = powm(w, q, p);
                t = powm(nr, q, p);
                r = powm(nr, (q + 1) >> 1, p);
                found = 0;
                for (rnd = 0; rnd <= s; rnd++) begin
                    y = t;
                    b = c;
                    if (t == 1) begin
                        found = 1;
                        break;
                    end
                    i = 0;
                    while (y != 1 && i < s) begin
                        y = mulm(y, y, p);
                        i++;
                    end
                    if (y != 1 || i >= s)
                        return mslc_pkg::ST_BADMOD;
                    for (k = 0; k + i + 1 < s; k++)
                        b = mulm(b, b, p);
                    r = mulm(r, b, p);
                    t = mulm(t, mulm(b, b, p), p);
                end
                if (!found)
                    return mslc_pkg::ST_BADMOD;
            end
            if (mulm(r, r, p) != nr)
                return mslc_pkg::ST_BADMOD;
            rt = r;
            return mslc_pkg::ST_OK;
        endfunction

        function t_root_result predict_root(bit [63:0] n, bit [63:0] p);
            t_root_result res;
            bit [63:0] nr, b, pp, n2, b2, diff, kq, inv;
            bit lift;
            lift = lift_exp >= 2;
            res.root   = 0;
            res.status = mslc_pkg::ST_OK;
            b = 0;
            if (p < 3 || p[0] == 0) begin
                res.status = mslc_pkg::ST_BADMOD;
            end else begin
                nr = n % p;
                if (nr == 0) begin
                    res.status = lift ? mslc_pkg::ST_NOLIFT : mslc_pkg::ST_OK;
                end else begin
                    res.status = root_mod_prime(nr, p, b);
                    if (res.status == mslc_pkg::ST_OK && lift) begin
                        pp   = p * p;
                        n2   = n % pp;
                        b2   = b * b;
                        diff = (n2 >= b2) ? (n2 - b2) : (n2 + (pp - b2));
                        kq   = (diff / p) % p;
                        if (!invm((2 * b) % p, p, inv))
                            res.status = mslc_pkg::ST_BADMOD;
                        else
                            res.root = b + mulm(kq, inv, p) * p;
                    end else if (res.status == mslc_pkg::ST_OK) begin
                        res.root = b;
                    end
                end
            end
            if (res.status != mslc_pkg::ST_OK)
                res.root = 0;
            return res;
        endfunction

        function void note_item(logic [63:0] n, logic [31:0] p);
            want_q.push_back(predict_root(n, {32'd0, p}));
            items++;
        endfunction

        function void check_result(logic [63:0] root, logic [1:0] status);
            t_root_result w;
            results++;
            if (want_q.size() == 0) begin
                $display("%0t: unexpected result root=%h status=%0d", $time, root, status);
                errors++;
                return;
            end
            w = want_q.pop_front();
            if (root !== w.root) begin
                $display("%0t: root mismatch expected %h actual %h", $time, w.root, root);
                errors++;
            end
            if (status !== w.status) begin
                $display("%0t: status mismatch expected %0d actual %0d",
                         $time, w.status, status);
                errors++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    mslc_in_if  item_if();
    mslc_cfg_if cfg_if();
    mslc_out_if res_if();

    modular_square_root_lift_core dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_if),
        .i_cfg    (cfg_if),
        .o_result (res_if)
    );

    sqrt_scoreboard sb;
    int send_idle_pct;
    int recv_stall_pct;
    bit hold_req;
    int hold_left;

    initial begin
        i_clk = 0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        repeat (LIMIT_CYCLES) @(posedge i_clk);
        $display("timeout after %0d cycles", LIMIT_CYCLES);
        $display("Some tests failed");
        $finish;
    end

    // result side with random stalls and one long hold-off
    initial begin
        res_if.ready <= 1'b0;
        hold_left = 0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            @(posedge i_clk);
            if (res_if.valid && res_if.ready)
                sb.check_result(res_if.root, res_if.status);
            if (hold_req) begin
                hold_req  = 0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    function automatic bit is_prime(bit [63:0] v);
        bit [63:0] d;
        if (v < 2)
            return 0;
        if (v[0] == 0)
            return v == 2;
        for (d = 3; d * d <= v; d += 2)
            if (v % d == 0)
                return 0;
        return 1;
    endfunction

    function automatic bit [31:0] next_prime(bit [31:0] start);
        bit [63:0] v;
        v = {32'd0, start} | 64'd1;
        while (!is_prime(v))
            v += 2;
        if (v > 64'hFFFF_FFFF)
            v = 64'd4294967291;
        return v[31:0];
    endfunction

    function automatic bit [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic send_item(logic [63:0] n, logic [31:0] p);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct && gap < 40)
            gap++;
        if (gap > 0) begin
            item_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        item_if.valid         <= 1'b1;
        item_if.residue_value <= n;
        item_if.prime_modulus <= p;
        @(posedge i_clk);
        while (!item_if.ready)
            @(posedge i_clk);
        sb.note_item(n, p);
    endtask

    task automatic wait_drained();
        item_if.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.want_q.size() != 0)
            @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    task automatic write_lift(logic [1:0] value);
        cfg_if.valid         <= 1'b1;
        cfg_if.lift_exponent <= value;
        @(posedge i_clk);
        while (!cfg_if.ready)
            @(posedge i_clk);
        sb.lift_exp = value;
        cfg_if.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_random_item();
        bit [31:0] small_composites[6] = '{9, 15, 21, 25, 45, 91};
        bit [63:0] n, rr;
        bit [31:0] p;
        int kind;
        kind = $urandom_range(99);
        if ($urandom_range(99) < 80)
            p = next_prime($urandom_range(3000, 3));
        else
            p = next_prime($urandom);
        n = rand64();
        if (kind < 8) begin
            case ($urandom_range(3))
                0: p = $urandom_range(2);
                1: p = $urandom & ~32'd1;
                default: p = ($urandom & ~32'd1) | 32'h8000_0000;
            endcase
        end else if (kind < 14) begin
            p = small_composites[$urandom_range(5)];
            if ($urandom_range(1))
                n = $urandom_range(3, 1);
        end else if (kind < 22) begin
            n = n - n % p;
        end else if (kind >= 35) begin
            rr = $urandom % p;
            n = (n / p) * p + (rr * rr) % p;
        end
        send_item(n, p);
    endtask

    initial begin
        logic [1:0] lift_plan[8] = '{2'd2, 2'd1, 2'd2, 2'd0, 2'd3, 2'd1, 2'd2, 2'd1};
        int mode;
        sb = new();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_req       = 0;
        i_rst_n               <= 1'b0;
        item_if.valid         <= 1'b0;
        item_if.residue_value <= '0;
        item_if.prime_modulus <= '0;
        cfg_if.valid          <= 1'b0;
        cfg_if.lift_exponent  <= mslc_pkg::LIFT_RESET;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed items at the reset lift setting
        send_item(64'd0, 32'd0);
        send_item(64'd5, 32'd1);
        send_item(64'd4, 32'd2);
        send_item(64'd10, 32'd4);
        send_item(64'd0, 32'd7);
        send_item(64'd49, 32'd7);
        send_item(64'd2, 32'd7);
        send_item(64'd3, 32'd7);
        send_item(64'hFFFF_FFFF_FFFF_FFFF, 32'd4294967291);
        send_item(64'd4, 32'd13);
        send_item(64'd10, 32'd13);
        send_item(64'd5, 32'd13);
        send_item(64'd2, 32'd65537);
        send_item(64'd9, 32'd3221225473);
        send_item(64'hFFFF_FFFF_FFFF_FFFF, 32'd3221225473);
        send_item(64'd1, 32'd9);
        send_item(64'd1, 32'd21);
        send_item(64'd1, 32'd25);
        send_item(64'd1, 32'd15);
        send_item(64'd123456789, 32'd2013265921);
        send_item(64'd4, 32'hFFFF_FFFF);
        send_item(64'h8000_0000_0000_0000, 32'd17);
        wait_drained();

        for (int ph = 0; ph < 8; ph++) begin
            mode = ph % 4;
            send_idle_pct  = (mode == 1) ? 52 : (mode == 3) ? 18 : 0;
            recv_stall_pct = (mode == 2) ? 52 : (mode == 3) ? 18 : 0;
            write_lift(lift_plan[ph]);
            if (ph == 2)
                hold_req = 1;
            for (int i = 0; i < 16; i++) begin
                send_random_item();
                if (ph == 5 && i == 9)
                    wait_drained();
            end
            wait_drained();
        end

        $display("covered %0d items, %0d results over lift settings 0..3",
                 sb.items, sb.results);
        $display("with stalls on both sides and a long result hold-off");
        if (sb.errors == 0 && sb.want_q.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
